// ===== hdl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the closest room search block.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int MAX_ROOMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ROOMS);
  localparam int CNT_W     = $clog2(MAX_ROOMS + 1);
  localparam int VAL_W     = 24;
  localparam int ROOM_W    = 2 * VAL_W;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_QUERY,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    STATUS_FOUND   = 3'd0,
    STATUS_NONE    = 3'd1,
    STATUS_ADDED   = 3'd2,
    STATUS_FULL    = 3'd3,
    STATUS_CLEARED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } bk_state_t;

  // For an add, a is the id and b the size; for a query, a is the preferred
  // id and b the minimum size.
  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } op_entry_t;

endpackage

// ===== hdl/crs_ram.sv =====
// ----------------------------------------------------------------------------
// crs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/crs_front.sv =====
// ----------------------------------------------------------------------------
// crs_front
// Accepts input transactions, decodes the command and queues the operation.
// ----------------------------------------------------------------------------
module crs_front
  import crs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [95:0] s_axis_tdata,
  input  logic [1:0] s_axis_tuser,
  output logic       q_valid,
  output op_entry_t  q_entry,
  input  logic       q_pop
);

  op_entry_t          entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] fill;
  op_entry_t          decoded;
  logic               push;

  always_comb begin
    decoded.a = s_axis_tdata[23:0];
    decoded.b = s_axis_tdata[47:24];
    unique case (s_axis_tuser)
      CMD_ADD: begin
        decoded.op = OP_ADD;
      end
      CMD_QUERY: begin
        decoded.op = OP_QUERY;
        decoded.a  = s_axis_tdata[71:48];
        decoded.b  = s_axis_tdata[95:72];
      end
      CMD_CLEAR: begin
        decoded.op = OP_CLEAR;
      end
      default: begin
        decoded.op = OP_BAD;
      end
    endcase
  end

  assign s_axis_tready = (fill != Q_CNT_W'(Q_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (fill != '0);
  assign q_entry       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= decoded;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/crs_back.sv =====
// ----------------------------------------------------------------------------
// crs_back
// Executes queued operations against the room table and drives the result.
// ----------------------------------------------------------------------------
module crs_back
  import crs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  op_entry_t        q_entry,
  output logic             q_pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,
  output logic [CNT_W-1:0] room_count
);

  bk_state_t        state;
  bk_state_t        state_next;
  logic [CNT_W-1:0] room_count_next;
  logic [CNT_W-1:0] issue;
  logic [CNT_W-1:0] issue_next;
  logic             rd_valid;
  logic             rd_en;
  logic [VAL_W-1:0] want;
  logic [VAL_W-1:0] min_size;
  logic             load_query;

  logic             s1_valid;
  logic             s1_qual;
  logic [VAL_W-1:0] s1_id;
  logic [VAL_W-1:0] s1_dist;

  logic             have;
  logic             have_next;
  logic [VAL_W-1:0] best_id;
  logic [VAL_W-1:0] best_id_next;
  logic [VAL_W-1:0] best_dist;
  logic [VAL_W-1:0] best_dist_next;

  logic             out_free;
  logic             out_load;
  status_t          out_status;
  logic [VAL_W-1:0] out_best;

  logic             we;
  logic [ROOM_W-1:0] rdata;
  logic [VAL_W-1:0] rd_id;
  logic [VAL_W-1:0] rd_size;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign rd_id    = rdata[ROOM_W-1:VAL_W];
  assign rd_size  = rdata[VAL_W-1:0];

  crs_ram #(
    .WIDTH(ROOM_W),
    .DEPTH(MAX_ROOMS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(room_count[ADDR_W-1:0]),
    .wdata({q_entry.a, q_entry.b}),
    .raddr(issue[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next      = state;
    room_count_next = room_count;
    issue_next      = issue;
    rd_en           = 1'b0;
    q_pop           = 1'b0;
    we              = 1'b0;
    load_query      = 1'b0;
    out_load        = 1'b0;
    out_status      = STATUS_NONE;
    out_best        = '0;
    have_next       = have;
    best_id_next    = best_id;
    best_dist_next  = best_dist;

    if (s1_valid && s1_qual &&
        (!have || s1_dist < best_dist || (s1_dist == best_dist && s1_id < best_id))) begin
      have_next      = 1'b1;
      best_id_next   = s1_id;
      best_dist_next = s1_dist;
    end

    unique case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_entry.op)
            OP_ADD: begin
              out_load = 1'b1;
              if (room_count < CNT_W'(MAX_ROOMS)) begin
                we              = 1'b1;
                room_count_next = room_count + 1'b1;
                out_status      = STATUS_ADDED;
              end else begin
                out_status = STATUS_FULL;
              end
            end
            OP_QUERY: begin
              if (room_count == '0) begin
                out_load = 1'b1;
              end else begin
                load_query = 1'b1;
                issue_next = '0;
                have_next  = 1'b0;
                state_next = BK_SCAN;
              end
            end
            OP_CLEAR: begin
              out_load        = 1'b1;
              room_count_next = '0;
              out_status      = STATUS_CLEARED;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_SCAN: begin
        if (issue < room_count) begin
          rd_en      = 1'b1;
          issue_next = issue + 1'b1;
        end else if (!rd_valid && !s1_valid) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = have ? STATUS_FOUND : STATUS_NONE;
          out_best   = have ? best_id : '0;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_query) begin
      want     <= q_entry.a;
      min_size <= q_entry.b;
    end
    s1_id   <= rd_id;
    s1_qual <= (rd_size >= min_size);
    s1_dist <= (rd_id >= want) ? (rd_id - want) : (want - rd_id);
    best_id   <= best_id_next;
    best_dist <= best_dist_next;
    issue     <= issue_next;
    if (out_load) begin
      m_axis_tuser <= out_status;
      m_axis_tdata <= out_best;
    end
    if (rst) begin
      state         <= BK_IDLE;
      room_count    <= '0;
      rd_valid      <= 1'b0;
      s1_valid      <= 1'b0;
      have          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state      <= state_next;
      room_count <= room_count_next;
      rd_valid   <= rd_en;
      s1_valid   <= rd_valid;
      have       <= have_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/closest_room_search_top.sv =====
// ----------------------------------------------------------------------------
// closest_room_search_top
// Add, clear and unknown commands, and a query on an empty table, answer
// from the idle state without a scan of the room table.
// Any other query scans every stored room, one stored room per cycle
// through the single read port of the room table.
// Throughput: one transaction at a time in the back end; the input queue
// holds two more. Synchronous reset empties the table and queue at once.
// ----------------------------------------------------------------------------
module closest_room_search_top
  import crs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // room_id, room_size, preferred_id, min_size
  input  logic [1:0]  s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // best_id
  output logic [2:0]  m_axis_tuser   // status
);

  logic             q_valid;
  op_entry_t        q_entry;
  logic             q_pop;
  logic [CNT_W-1:0] room_count;

  crs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  crs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .room_count   (room_count)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    room_count <= CNT_W'(MAX_ROOMS))
    else $error("room count beyond table size");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_best_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != STATUS_FOUND) |-> (m_axis_tdata == '0))
    else $error("best id not zero on a non-found result");

endmodule
